[hw/rtl/crrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrd_pkg
// Shared types and constants for the credit round-robin dispatcher.
// ----------------------------------------------------------------------------
package crrd_pkg;

    // table geometry
    localparam int MAX_NODES   = 32;
    localparam int CREDIT_BITS = 8;
    localparam int IDX_W       = $clog2(MAX_NODES);
    // largest cube dimension whose node count fits the table
    localparam int MAX_DIM     = $clog2(MAX_NODES + 1) - 1;
    localparam int ACT_NODES   = 1 << MAX_DIM;

    // fixed field widths
    localparam int MODE_W   = 3;
    localparam int NODE_W   = 5;
    localparam int CRED_W   = 8;
    localparam int SUM_W    = 13;
    localparam int DIM_W    = 3;
    localparam int CFG_W    = 5;
    localparam int CFG_IX_W = 1;

    // command modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DFLT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPTR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TAKE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_NODE_ID = 1'd0;
    localparam logic [CFG_IX_W-1:0] CFG_HC_DIM  = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node;
        logic [CRED_W-1:0] credit;
    } cmd_t;

    typedef struct packed {
        logic              granted;
        logic [NODE_W-1:0] target;
        logic [SUM_W-1:0]  total_credits;
    } rsp_t;

    // search request and answer
    typedef struct packed {
        logic [IDX_W-1:0] ptr;
        logic [IDX_W-1:0] own;
        logic [IDX_W-1:0] mask;
        logic             skip_own;
    } srch_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } srch_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MODIFY,
        S_NEIGH
    } state_t;

endpackage

[hw/rtl/crrd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crrd_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/crrd_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrd_search
// Round-robin priority search over the nonzero-credit flags.
// ----------------------------------------------------------------------------
module crrd_search (
    input  logic [crrd_pkg::MAX_NODES-1:0] nz,
    input  crrd_pkg::srch_req_t            req,
    output crrd_pkg::srch_rsp_t            rsp
);

    logic [crrd_pkg::MAX_NODES-1:0] cand;
    logic [crrd_pkg::MAX_NODES-1:0] upper;

    // eligible nodes: inside the cube, with credit, own node skipped for peek
    always_comb
    begin
        for (int i = 0; i < crrd_pkg::MAX_NODES; i++)
        begin
            cand[i] = nz[i]
                && (i < crrd_pkg::ACT_NODES)
                && ((crrd_pkg::IDX_W'(i) & ~req.mask) == '0)
                && !(req.skip_own && (crrd_pkg::IDX_W'(i) == req.own));
            upper[i] = cand[i] && (crrd_pkg::IDX_W'(i) >= req.ptr);
        end
    end

    // lowest set bit at or above the pointer, else lowest overall (wrap)
    always_comb
    begin
        rsp.found = |cand;
        rsp.idx   = '0;
        if (|upper)
        begin
            for (int i = crrd_pkg::MAX_NODES - 1; i >= 0; i--)
            begin
                if (upper[i])
                begin
                    rsp.idx = crrd_pkg::IDX_W'(i);
                end
            end
        end
        else
        begin
            for (int i = crrd_pkg::MAX_NODES - 1; i >= 0; i--)
            begin
                if (cand[i])
                begin
                    rsp.idx = crrd_pkg::IDX_W'(i);
                end
            end
        end
    end

endmodule

[hw/rtl/credit_round_robin_dispatcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_round_robin_dispatcher
// Credit-based round-robin target selection over hypercube nodes.
// ----------------------------------------------------------------------------
//  channel  signals                          flow
//  command  start, busy, cmd                 in,  taken on start && !busy
//  result   done, result                     out, one-cycle strobe, no stall
//  config   cfg_valid, cfg_ready, cfg_index, in,  taken on valid && ready
//           cfg_data
//
//  Set pointer, peek, unused modes, take without grant: done from the execute state.
//  Load and take with grant: execute, then modify (credit RAM read, then modify-write).
//  Default neighbours: execute, then one neighbour state per dimension, one RAM write per neighbour.
//  busy is high from the accepting edge until done; start may rise with done.
//  Reset clears the credit flags, sum and pointer; config returns to defaults.
//  The result side cannot stall.
// ----------------------------------------------------------------------------
module credit_round_robin_dispatcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  crrd_pkg::cmd_t                  cmd,
    output logic                            done,
    output crrd_pkg::rsp_t                  result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crrd_pkg::CFG_IX_W-1:0]   cfg_index,
    input  logic [crrd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IW = crrd_pkg::IDX_W;
    localparam int CB = crrd_pkg::CREDIT_BITS;

    crrd_pkg::state_t                  state_reg, state_next;
    crrd_pkg::cmd_t                    item_reg, item_next;
    logic [crrd_pkg::NODE_W-1:0]       node_id_reg;
    logic [crrd_pkg::DIM_W-1:0]        hc_dim_reg;
    logic [crrd_pkg::MAX_NODES-1:0]    nz_reg, nz_next;
    logic [crrd_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [IW-1:0]                     ptr_reg, ptr_next;
    logic [IW-1:0]                     addr_reg, addr_next;
    logic [crrd_pkg::DIM_W-1:0]        nb_reg, nb_next;
    logic                              done_reg, done_next;
    crrd_pkg::rsp_t                    rsp_reg, rsp_next;

    logic                              mem_we, mem_re;
    logic [IW-1:0]                     mem_waddr, mem_raddr;
    logic [CB-1:0]                     mem_wdata, mem_rdata;

    logic [crrd_pkg::DIM_W-1:0]        dim_eff;
    logic [IW-1:0]                     mask;
    logic [IW-1:0]                     own;
    logic [CB-1:0]                     old_val, new_val;
    logic [crrd_pkg::MAX_NODES-1:0]    nb_vec;
    crrd_pkg::srch_req_t               sreq;
    crrd_pkg::srch_rsp_t               srsp;
    logic                              accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != crrd_pkg::S_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign cfg_ready = 1'b1;

    // active cube geometry
    always_comb
    begin
        if (int'(hc_dim_reg) > crrd_pkg::MAX_DIM)
        begin
            dim_eff = crrd_pkg::DIM_W'(crrd_pkg::MAX_DIM);
        end
        else
        begin
            dim_eff = hc_dim_reg;
        end
        for (int i = 0; i < IW; i++)
        begin
            mask[i] = (i < int'(dim_eff));
        end
        own = IW'(node_id_reg) & mask;
    end

    // neighbour flags for default mode
    always_comb
    begin
        nb_vec = '0;
        for (int i = 0; i < crrd_pkg::MAX_DIM; i++)
        begin
            if (i < int'(dim_eff))
            begin
                nb_vec[own ^ (IW'(1) << i)] = 1'b1;
            end
        end
    end

    // search request
    always_comb
    begin
        sreq.ptr      = ptr_reg & mask;
        sreq.own      = own;
        sreq.mask     = mask;
        sreq.skip_own = (item_reg.mode == crrd_pkg::MODE_PEEK);
    end

    crrd_search u_search (
        .nz  (nz_reg),
        .req (sreq),
        .rsp (srsp)
    );

    crrd_ram #(
        .DEPTH (crrd_pkg::MAX_NODES),
        .WIDTH (CB)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // an entry without its flag holds zero credit
    assign old_val = nz_reg[addr_reg] ? mem_rdata : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crrd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = crrd_pkg::S_EXEC;
                end
            end
            crrd_pkg::S_EXEC:
            begin
                case (item_reg.mode)
                    crrd_pkg::MODE_LOAD:
                    begin
                        if (int'(item_reg.node) < crrd_pkg::MAX_NODES)
                        begin
                            state_next = crrd_pkg::S_MODIFY;
                        end
                        else
                        begin
                            state_next = crrd_pkg::S_IDLE;
                        end
                    end
                    crrd_pkg::MODE_DFLT:
                    begin
                        if (dim_eff != '0)
                        begin
                            state_next = crrd_pkg::S_NEIGH;
                        end
                        else
                        begin
                            state_next = crrd_pkg::S_IDLE;
                        end
                    end
                    crrd_pkg::MODE_TAKE:
                    begin
                        if ((sum_reg != '0) && srsp.found)
                        begin
                            state_next = crrd_pkg::S_MODIFY;
                        end
                        else
                        begin
                            state_next = crrd_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = crrd_pkg::S_IDLE;
                    end
                endcase
            end
            crrd_pkg::S_MODIFY:
            begin
                state_next = crrd_pkg::S_IDLE;
            end
            crrd_pkg::S_NEIGH:
            begin
                if (nb_reg == dim_eff - 1'b1)
                begin
                    state_next = crrd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = crrd_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next = item_reg;
        nz_next   = nz_reg;
        sum_next  = sum_reg;
        ptr_next  = ptr_reg;
        addr_next = addr_reg;
        nb_next   = nb_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        new_val   = '0;

        // default result: no grant, current total
        rsp_next.granted       = 1'b0;
        rsp_next.target        = '0;
        rsp_next.total_credits = sum_reg;

        case (state_reg)
            crrd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next = cmd;
                end
            end
            crrd_pkg::S_EXEC:
            begin
                case (item_reg.mode)
                    crrd_pkg::MODE_LOAD:
                    begin
                        addr_next = IW'(item_reg.node);
                        mem_re    = 1'b1;
                        mem_raddr = IW'(item_reg.node);
                        if (int'(item_reg.node) >= crrd_pkg::MAX_NODES)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    crrd_pkg::MODE_DFLT:
                    begin
                        nz_next  = nb_vec;
                        sum_next = crrd_pkg::SUM_W'(dim_eff);
                        ptr_next = (own + 1'b1) & mask;
                        nb_next  = '0;
                        rsp_next.total_credits = crrd_pkg::SUM_W'(dim_eff);
                        if (dim_eff == '0)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    crrd_pkg::MODE_SPTR:
                    begin
                        ptr_next  = IW'(item_reg.node) & mask;
                        done_next = 1'b1;
                    end
                    crrd_pkg::MODE_TAKE:
                    begin
                        addr_next = srsp.idx;
                        mem_re    = 1'b1;
                        mem_raddr = srsp.idx;
                        if (!((sum_reg != '0) && srsp.found))
                        begin
                            done_next = 1'b1;
                        end
                    end
                    crrd_pkg::MODE_PEEK:
                    begin
                        done_next = 1'b1;
                        if ((sum_reg != '0) && srsp.found)
                        begin
                            rsp_next.granted = 1'b1;
                            rsp_next.target  = crrd_pkg::NODE_W'(srsp.idx);
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            crrd_pkg::S_MODIFY:
            begin
                // read data arrived; write back the new credit
                done_next = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                if (item_reg.mode == crrd_pkg::MODE_LOAD)
                begin
                    new_val  = CB'(item_reg.credit);
                    sum_next = sum_reg - crrd_pkg::SUM_W'(old_val)
                             + crrd_pkg::SUM_W'(new_val);
                end
                else
                begin
                    new_val  = old_val - 1'b1;
                    sum_next = sum_reg - 1'b1;
                    ptr_next = (addr_reg + 1'b1) & mask;
                    rsp_next.granted = 1'b1;
                    rsp_next.target  = crrd_pkg::NODE_W'(addr_reg);
                end
                mem_wdata        = new_val;
                nz_next[addr_reg] = (new_val != '0);
                rsp_next.total_credits = sum_next;
            end
            crrd_pkg::S_NEIGH:
            begin
                // one neighbour credit per cycle
                mem_we    = 1'b1;
                mem_waddr = own ^ (IW'(1) << nb_reg);
                mem_wdata = CB'(1);
                nb_next   = nb_reg + 1'b1;
                if (nb_reg == dim_eff - 1'b1)
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crrd_pkg::S_IDLE;
            nz_reg    <= '0;
            sum_reg   <= '0;
            ptr_reg   <= '0;
            nb_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nz_reg    <= nz_next;
            sum_reg   <= sum_next;
            ptr_reg   <= ptr_next;
            nb_reg    <= nb_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        addr_reg <= addr_next;
        if (done_next)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
            hc_dim_reg  <= crrd_pkg::DIM_W'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crrd_pkg::CFG_NODE_ID:
                begin
                    node_id_reg <= cfg_data[crrd_pkg::NODE_W-1:0];
                end
                crrd_pkg::CFG_HC_DIM:
                begin
                    hc_dim_reg <= cfg_data[crrd_pkg::DIM_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
